// ===== rtl/phase_row_cross_check_matcher_assert.svh =====
// Assertion macros for the phase row cross-check matcher.
// Used by the top level; no other dependencies.
`ifndef PHASE_ROW_CROSS_CHECK_MATCHER_ASSERT_SVH
`define PHASE_ROW_CROSS_CHECK_MATCHER_ASSERT_SVH
`ifndef SYNTHESIS
// Check a property on every rising edge outside reset.
`define PRCC_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("phase row matcher assertion failed");
// Check a property on every rising edge, reset included.
`define PRCC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("phase row matcher assertion failed");
`else
`define PRCC_ASSERT(lbl, clk, rst, prop)
`define PRCC_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== rtl/prcc_pkg.sv =====
// Package for the phase row cross-check matcher: widths, register map,
// request codes and sequencer states. No dependencies.
`timescale 1ns / 1ps
package prcc_pkg;

  localparam int PHASE_W = 20;
  localparam int COL_W   = 10;
  localparam int TAG_W   = 12;
  localparam int RW_W    = 11;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  localparam logic [PHASE_W-1:0] MIN_PHASE_RST = 20'd25736; // two pi, Q8.12
  localparam logic [PHASE_W-1:0] THRESH_RST    = 20'd41;    // 0.01, Q8.12
  localparam logic [RW_W-1:0]    ROW_WIDTH_RST = 11'd1024;

  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_MIN_PHASE = 2'd0;
  localparam reg_idx_t REG_THRESHOLD = 2'd1;
  localparam reg_idx_t REG_ROW_WIDTH = 2'd2;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LREAD,
    ST_LCHK,
    ST_SCAN_R,
    ST_SCAN_L,
    ST_DONE
  } state_t;

endpackage

// ===== rtl/prcc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module prcc_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/prcc_cmp.sv =====
// Shared phase compare unit: absolute difference against the match threshold.
// Depends on prcc_pkg.
`timescale 1ns / 1ps
module prcc_cmp (
  input  logic [prcc_pkg::PHASE_W-1:0] phase_a,
  input  logic [prcc_pkg::PHASE_W-1:0] phase_b,
  input  logic [prcc_pkg::PHASE_W-1:0] threshold,
  output logic                         hit
);
  import prcc_pkg::*;

  logic [PHASE_W-1:0] diff;

  always_comb begin
    diff = (phase_a > phase_b) ? (phase_a - phase_b) : (phase_b - phase_a);
    hit  = (diff <= threshold);
  end

endmodule

// ===== rtl/phase_row_cross_check_matcher.sv =====
// Phase row cross-check matcher. A load transfer returns nothing. Query run time
// grows with k1/k2, the right and left hit columns, and is bounded by active width
// W, set by one read a cycle per row RAM through a single shared compare unit.
// s_tready is low while a query runs and while its result waits for the output
// register to drain.
// Reset (rst, synchronous) restores the registers to defaults and idles the sequencer;
// the row RAMs are not cleared and must be loaded before they are queried.
`timescale 1ns / 1ps
`include "phase_row_cross_check_matcher_assert.svh"
module phase_row_cross_check_matcher #(
  parameter int ROW_MAX = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  // APB configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [prcc_pkg::ADDR_W-1:0]  paddr,
  input  logic [prcc_pkg::DATA_W-1:0]  pwdata,
  output logic [prcc_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  // input stream
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [63:0]                  s_tdata,  // column[9:0], left_phase[29:10],
                                                 // right_phase[49:30], row_tag[61:50]
  input  logic                         s_tuser,  // req_type
  // result stream
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [31:0]                  m_tdata,  // left_x[9:0], right_x[19:10],
                                                 // row_out[31:20]
  output logic                         m_tuser   // found
);
  import prcc_pkg::*;

  localparam int AW = $clog2(ROW_MAX);          // RAM address width
  localparam int CW = $clog2(ROW_MAX + 1);      // scan counter, holds W itself
  localparam int EW = ((CW > COL_W) ? CW : COL_W) + 1;

  // configuration registers
  logic [PHASE_W-1:0] min_phase;
  logic [PHASE_W-1:0] match_threshold;
  logic [RW_W-1:0]    row_width;

  // input field split
  logic [COL_W-1:0]   in_column;
  logic [PHASE_W-1:0] in_left_phase;
  logic [PHASE_W-1:0] in_right_phase;
  logic [TAG_W-1:0]   in_row_tag;

  // sequencer state
  state_t             state, state_next;
  logic [CW-1:0]      ka, ka_next;        // next address to issue
  logic [AW-1:0]      kc, kc_next;        // address of data now on the RAM output
  logic               qv, qv_next;        // RAM output holds scan data
  logic [PHASE_W-1:0] lv, lv_next;
  logic [PHASE_W-1:0] rv, rv_next;
  logic [AW-1:0]      k1, k1_next;
  logic [COL_W-1:0]   x_r, x_r_next;
  logic [TAG_W-1:0]   tag_r, tag_r_next;
  logic               found_r, found_r_next;
  logic [COL_W-1:0]   lx_r, lx_r_next;

  // output register
  logic               m_tvalid_next;
  logic               m_found, m_found_next;
  logic [COL_W-1:0]   m_lx, m_lx_next;
  logic [COL_W-1:0]   m_rx, m_rx_next;
  logic [TAG_W-1:0]   m_row, m_row_next;

  // RAM ports and compare unit
  logic               load_we;
  logic [AW-1:0]      waddr;
  logic [AW-1:0]      l_raddr, r_raddr;
  logic [PHASE_W-1:0] left_q, right_q;
  logic [PHASE_W-1:0] cmp_a, cmp_b;
  logic               cmp_hit;

  logic [CW-1:0]      width_act;
  logic               s_xfer, cfg_wr, issue;
  logic [EW-1:0]      xe, ke, sum;
  logic               adjacent;

  assign in_column      = s_tdata[9:0];
  assign in_left_phase  = s_tdata[29:10];
  assign in_right_phase = s_tdata[49:30];
  assign in_row_tag     = s_tdata[61:50];

  // ---------------------------------------------------------------------------
  // Configuration port: always ready, write on the access phase
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_phase       <= MIN_PHASE_RST;
      match_threshold <= THRESH_RST;
      row_width       <= ROW_WIDTH_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_MIN_PHASE: min_phase       <= pwdata[PHASE_W-1:0];
        REG_THRESHOLD: match_threshold <= pwdata[PHASE_W-1:0];
        REG_ROW_WIDTH: row_width       <= pwdata[RW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_MIN_PHASE: prdata = DATA_W'(min_phase);
      REG_THRESHOLD: prdata = DATA_W'(match_threshold);
      REG_ROW_WIDTH: prdata = DATA_W'(row_width);
      default:       prdata = '0;
    endcase
  end

  // Active width: row_width clipped to the store depth.
  assign width_act = (32'(row_width) < ROW_MAX) ? CW'(row_width) : CW'(ROW_MAX);

  // ---------------------------------------------------------------------------
  // Row stores: loads write both in the accept cycle; drop columns past the store
  // ---------------------------------------------------------------------------
  assign s_tready = (state == ST_IDLE);
  assign s_xfer   = s_tvalid & s_tready;
  assign load_we  = s_xfer & (s_tuser == REQ_LOAD) & (32'(in_column) < ROW_MAX);
  assign waddr    = AW'(in_column);

  // Left port serves the query column read, then the back-match scan.
  assign l_raddr = (state == ST_LREAD) ? AW'(x_r) : ka[AW-1:0];
  assign r_raddr = ka[AW-1:0];

  prcc_ram #(.WIDTH(PHASE_W), .DEPTH(ROW_MAX)) u_left_ram (
    .clk   (clk),
    .we    (load_we),
    .waddr (waddr),
    .wdata (in_left_phase),
    .raddr (l_raddr),
    .rdata (left_q)
  );

  prcc_ram #(.WIDTH(PHASE_W), .DEPTH(ROW_MAX)) u_right_ram (
    .clk   (clk),
    .we    (load_we),
    .waddr (waddr),
    .wdata (in_right_phase),
    .raddr (r_raddr),
    .rdata (right_q)
  );

  // One compare unit: left phase vs right row, then right hit vs left row.
  assign cmp_a = (state == ST_SCAN_L) ? rv : lv;
  assign cmp_b = (state == ST_SCAN_L) ? left_q : right_q;

  prcc_cmp u_cmp (
    .phase_a   (cmp_a),
    .phase_b   (cmp_b),
    .threshold (match_threshold),
    .hit       (cmp_hit)
  );

  // Cross-check: back-matched column must sit within one of the query column.
  assign xe       = EW'(x_r);
  assign ke       = EW'(kc);
  assign sum      = xe + ke;
  assign adjacent = (xe == ke) || (xe == ke + EW'(1)) || (ke == xe + EW'(1));
  assign issue    = (ka < width_act);

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      qv       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      qv       <= qv_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  always_ff @(posedge clk) begin
    ka      <= ka_next;
    kc      <= kc_next;
    lv      <= lv_next;
    rv      <= rv_next;
    k1      <= k1_next;
    x_r     <= x_r_next;
    tag_r   <= tag_r_next;
    found_r <= found_r_next;
    lx_r    <= lx_r_next;
    m_found <= m_found_next;
    m_lx    <= m_lx_next;
    m_rx    <= m_rx_next;
    m_row   <= m_row_next;
  end

  always_comb begin
    state_next    = state;
    ka_next       = ka;
    kc_next       = kc;
    qv_next       = qv;
    lv_next       = lv;
    rv_next       = rv;
    k1_next       = k1;
    x_r_next      = x_r;
    tag_r_next    = tag_r;
    found_r_next  = found_r;
    lx_r_next     = lx_r;
    m_found_next  = m_found;
    m_lx_next     = m_lx;
    m_rx_next     = m_rx;
    m_row_next    = m_row;
    m_tvalid_next = m_tvalid & ~m_tready;

    case (state)
      ST_IDLE: begin
        if (s_xfer && (s_tuser == REQ_QUERY)) begin
          x_r_next     = in_column;
          tag_r_next   = in_row_tag;
          found_r_next = 1'b0;
          // A column outside the active row gives no match.
          state_next   = (32'(in_column) < 32'(width_act)) ? ST_LREAD : ST_DONE;
        end
      end
      ST_LREAD: begin
        state_next = ST_LCHK;
      end
      ST_LCHK: begin
        lv_next = left_q;
        ka_next = '0;
        qv_next = 1'b0;
        state_next = (left_q > min_phase) ? ST_SCAN_R : ST_DONE;
      end
      ST_SCAN_R: begin
        ka_next = issue ? ka + CW'(1) : ka;
        qv_next = issue;
        kc_next = ka[AW-1:0];
        if (qv && cmp_hit) begin
          k1_next    = kc;
          rv_next    = right_q;
          ka_next    = '0;
          qv_next    = 1'b0;
          state_next = ST_SCAN_L;
        end else if (!issue && !qv) begin
          state_next = ST_DONE;
        end
      end
      ST_SCAN_L: begin
        ka_next = issue ? ka + CW'(1) : ka;
        qv_next = issue;
        kc_next = ka[AW-1:0];
        if (qv && cmp_hit) begin
          found_r_next = adjacent;
          lx_r_next    = sum[COL_W:1];
          qv_next      = 1'b0;
          state_next   = ST_DONE;
        end else if (!issue && !qv) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        // Hold until the output register is free, then hand the result over.
        if (!m_tvalid || m_tready) begin
          m_tvalid_next = 1'b1;
          m_found_next  = found_r;
          m_lx_next     = found_r ? lx_r : '0;
          m_rx_next     = found_r ? COL_W'(k1) : '0;
          m_row_next    = tag_r;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign m_tdata = {m_row, m_rx, m_lx};
  assign m_tuser = m_found;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `PRCC_ASSERT(a_query_starts, clk, rst, (s_tvalid && s_tready && s_tuser) |=> (state != ST_IDLE))
  `PRCC_ASSERT(a_scan_in_row, clk, rst, ((state == ST_SCAN_R || state == ST_SCAN_L) && qv) |-> (CW'(kc) < width_act))
  `PRCC_ASSERT(a_reject_zero, clk, rst, (m_tvalid && !m_tuser) |-> (m_tdata[19:0] == 20'd0))
  `PRCC_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> (!m_tvalid && state == ST_IDLE))

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the phase row cross-check matcher.
// Depends on prcc_pkg and the phase_row_cross_check_matcher RTL.
`timescale 1ns / 1ps
module testbench;
  import prcc_pkg::*;

  localparam int ROW_MAX      = 1024;
  localparam int HOLD_CYCLES  = 400;               // long receiver hold-off
  localparam int DRAIN_CYCLES = 2 * ROW_MAX + 8;   // one full query plus margin
  localparam int TIMEOUT_NS   = 8_000_000;

  localparam logic TYPED     = 1'b1;  // expectation written into the table
  localparam logic PREDICTED = 1'b0;  // expectation taken from the predictor

  // One result transfer, fields as they leave the block.
  typedef struct packed {
    logic                found;
    logic [COL_W-1:0]    left_x;
    logic [COL_W-1:0]    right_x;
    logic [TAG_W-1:0]    row_out;
  } match_t;

  // One input transfer, plus an optional hand-typed expectation.
  typedef struct packed {
    logic                req;
    logic [COL_W-1:0]    col;
    logic [PHASE_W-1:0]  lp;
    logic [PHASE_W-1:0]  rp;
    logic [TAG_W-1:0]    tag;
    logic                typed;
    match_t              want;
  } pixel_req_t;

  logic                clk;
  logic                rst = 1'b1;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [63:0]         s_tdata = '0;   // column[9:0], left_phase[29:10],
                                       // right_phase[49:30], row_tag[61:50]
  logic                s_tuser = 1'b0; // req_type
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [31:0]         m_tdata;        // left_x[9:0], right_x[19:10], row_out[31:20]
  logic                m_tuser;        // found

  // Shadow copy of the block's configuration and row stores.
  logic [PHASE_W-1:0]  cfg_min_phase = MIN_PHASE_RST;
  logic [PHASE_W-1:0]  cfg_match_thr = THRESH_RST;
  logic [RW_W-1:0]     cfg_row_width = ROW_WIDTH_RST;
  logic [PHASE_W-1:0]  left_phase_row  [ROW_MAX];
  logic [PHASE_W-1:0]  right_phase_row [ROW_MAX];
  bit                  col_loaded      [ROW_MAX];

  match_t              pending_matches [$];
  match_t              want_match;
  int                  mismatch_count = 0;

  int                  send_idle_pct = 0;
  int                  recv_idle_pct = 0;
  bit                  hold_req = 1'b0;

  pixel_req_t          directed_tbl [23];

  phase_row_cross_check_matcher #(.ROW_MAX(ROW_MAX)) uut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #(TIMEOUT_NS);
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic [PHASE_W-1:0] phase_gap(logic [PHASE_W-1:0] a,
                                                   logic [PHASE_W-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  // Apply one accepted transfer to the shadow state. Loads update the row
  // stores; queries run both scans and the cross-check and return the result.
  function automatic match_t predict_step(pixel_req_t it);
    int unsigned        w, k1, k2;
    logic [PHASE_W-1:0] lv, rv;
    match_t             res;
    res = '0;
    res.row_out = it.tag;
    if (it.req == REQ_LOAD) begin
      left_phase_row[it.col]  = it.lp;
      right_phase_row[it.col] = it.rp;
      col_loaded[it.col]      = 1'b1;
      return res;
    end
    w = (cfg_row_width < ROW_MAX) ? cfg_row_width : ROW_MAX;
    if (it.col < w && left_phase_row[it.col] > cfg_min_phase) begin
      lv = left_phase_row[it.col];
      k1 = 0;
      while (k1 < w && phase_gap(lv, right_phase_row[k1]) > cfg_match_thr) k1++;
      if (k1 < w) begin
        rv = right_phase_row[k1];
        k2 = 0;
        while (k2 < w && phase_gap(rv, left_phase_row[k2]) > cfg_match_thr) k2++;
        // Accept only when the back-matched column sits within one of the query.
        if (k2 < w && k2 + 1 >= it.col && k2 <= it.col + 1) begin
          res.found   = 1'b1;
          res.left_x  = COL_W'((it.col + k2) >> 1);
          res.right_x = COL_W'(k1);
        end
      end
    end
    return res;
  endfunction

  function automatic pixel_req_t dir_row(logic req, int col, int lp, int rp, int tag,
                                         logic typed, logic found, int lx, int rx);
    pixel_req_t r;
    r.req   = req;
    r.col   = COL_W'(col);
    r.lp    = PHASE_W'(lp);
    r.rp    = PHASE_W'(rp);
    r.tag   = TAG_W'(tag);
    r.typed = typed;
    r.want.found   = found;
    r.want.left_x  = COL_W'(lx);
    r.want.right_x = COL_W'(rx);
    r.want.row_out = TAG_W'(tag);
    return r;
  endfunction

  // Offer one item on the input stream; start and end at a falling edge.
  // Leave tvalid high afterwards so back-to-back items need no toggle.
  task automatic send_item(input pixel_req_t it);
    match_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= it.req;
    s_tdata  <= {2'b00, it.tag, it.rp, it.lp, it.col};
    do @(posedge clk); while (!s_tready);
    predicted = predict_step(it);
    if (it.req == REQ_QUERY)
      pending_matches.insert(pending_matches.size(), it.typed ? it.want : predicted);
    @(negedge clk);
  endtask

  // Drop tvalid, wait for every outstanding result, then let the block settle.
  task automatic drain_results(input int settle);
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (pending_matches.size() != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  // APB write: setup, access, then an idle gap so writes never touch.
  task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_MIN_PHASE: cfg_min_phase = val[PHASE_W-1:0];
      REG_THRESHOLD: cfg_match_thr = val[PHASE_W-1:0];
      REG_ROW_WIDTH: cfg_row_width = val[RW_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // One configuration setting: drain, program all registers, reload the row
  // as a disparity ramp (when asked), then run random loads and queries.
  task automatic run_phase(input int unsigned min_ph, input int unsigned thr,
                           input int w, input int n, input int sidle, input int ridle,
                           input bit fill, input bit hold, input bit pause);
    int unsigned step, base, shift;
    int          c, i, roll;
    pixel_req_t  it;
    drain_results(DRAIN_CYCLES);
    write_reg(REG_MIN_PHASE, min_ph);
    write_reg(REG_THRESHOLD, thr);
    write_reg(REG_ROW_WIDTH, w);
    send_idle_pct = sidle;
    recv_idle_pct = ridle;

    // Ramp rows: right column c carries the left phase of column c+shift,
    // with a step near the threshold so neighbor back-matches show up.
    // Start the ramp below min_phase so part of the row gets rejected.
    if (fill) begin
      step  = $urandom_range(thr / 2 + 1, 3 * thr + 2);
      shift = $urandom_range(0, 3);
      base  = min_ph - step * (w / 4);
      for (c = 0; c < w; c++) begin
        it = '0;
        it.req = REQ_LOAD;
        it.col = COL_W'(c);
        it.lp  = PHASE_W'(base + c * step + $urandom_range(0, thr / 2));
        it.rp  = PHASE_W'(base + (c + shift) * step + $urandom_range(0, thr / 2));
        if ($urandom_range(0, 9) == 0) it.lp = PHASE_W'($urandom);
        if ($urandom_range(0, 9) == 0) it.rp = PHASE_W'($urandom);
        send_item(it);
      end
    end

    for (i = 0; i < n; i++) begin
      // Hold the receiver off while queries keep coming, to back up the block.
      if (hold && i == 0) hold_req = 1'b1;
      // Stop offering mid-phase until every result is back.
      if (pause && i == n / 2) drain_results(0);
      it = '0;
      it.lp  = PHASE_W'($urandom);
      it.rp  = PHASE_W'($urandom);
      it.tag = TAG_W'($urandom_range(0, 4095));
      roll   = $urandom_range(0, 99);
      if (roll < 25) begin
        // Nudge an in-row column, keeping the ramp mostly intact.
        it.req = REQ_LOAD;
        it.col = COL_W'($urandom_range(0, w - 1));
        it.lp  = PHASE_W'(left_phase_row[it.col] + $urandom_range(0, thr / 2 + 1));
        it.rp  = PHASE_W'(right_phase_row[it.col] + $urandom_range(0, thr / 2 + 1));
      end else if (roll < 30) begin
        it.req = REQ_LOAD;
        it.col = COL_W'($urandom_range(0, ROW_MAX - 1));
      end else if (roll < 40 && w < ROW_MAX) begin
        // Query past the row end, only at a column that holds data.
        it.req = REQ_QUERY;
        it.col = COL_W'($urandom_range(w, ROW_MAX - 1));
        if (!col_loaded[it.col]) it.col = COL_W'(ROW_MAX - 1);
      end else begin
        it.req = REQ_QUERY;
        it.col = COL_W'($urandom_range(0, w - 1));
      end
      send_item(it);
    end
  endtask

  // Receiver: random tready, or a long hold-off counted here on request.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Compare every result transfer with the oldest outstanding expectation.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_matches.size() == 0) begin
        $error("unexpected result transfer: row_out %0d", m_tdata[31:20]);
        mismatch_count++;
      end else begin
        want_match = pending_matches.pop_front();
        if (m_tuser !== want_match.found) begin
          $error("found: expected %0d, got %0d", want_match.found, m_tuser);
          mismatch_count++;
        end
        if (m_tdata[9:0] !== want_match.left_x) begin
          $error("left_x: expected %0d, got %0d", want_match.left_x, m_tdata[9:0]);
          mismatch_count++;
        end
        if (m_tdata[19:10] !== want_match.right_x) begin
          $error("right_x: expected %0d, got %0d", want_match.right_x, m_tdata[19:10]);
          mismatch_count++;
        end
        if (m_tdata[31:20] !== want_match.row_out) begin
          $error("row_out: expected %0d, got %0d", want_match.row_out, m_tdata[31:20]);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    // Directed rows run at row_width 4 with min_phase and threshold at reset.
    directed_tbl[0]  = dir_row(REQ_LOAD,     0,   30000,   30000,    0, PREDICTED, 0, 0, 0);
    directed_tbl[1]  = dir_row(REQ_LOAD,     1,   40000,   50000,    0, PREDICTED, 0, 0, 0);
    directed_tbl[2]  = dir_row(REQ_LOAD,     2,   50000,   40000,    0, PREDICTED, 0, 0, 0);
    // phase equal to min_phase: must be rejected, not strictly above
    directed_tbl[3]  = dir_row(REQ_LOAD,     3,   25736,       0,    0, PREDICTED, 0, 0, 0);
    directed_tbl[4]  = dir_row(REQ_LOAD,     4, 1048575, 1048575,    0, PREDICTED, 0, 0, 0);
    directed_tbl[5]  = dir_row(REQ_LOAD,  1023,       0,       0,    0, PREDICTED, 0, 0, 0);
    directed_tbl[6]  = dir_row(REQ_QUERY,    0,       0,       0,    0, TYPED,     1, 0, 0);
    directed_tbl[7]  = dir_row(REQ_QUERY,    1, 1048575, 1048575, 4095, PREDICTED, 0, 0, 0);
    directed_tbl[8]  = dir_row(REQ_QUERY,    2,       0,       0, 1365, PREDICTED, 0, 0, 0);
    directed_tbl[9]  = dir_row(REQ_QUERY,    3,       0,       0, 2730, TYPED,     0, 0, 0);
    // query columns outside the active row
    directed_tbl[10] = dir_row(REQ_QUERY,    4,       0,       0,    7, TYPED,     0, 0, 0);
    directed_tbl[11] = dir_row(REQ_QUERY, 1023,       0,       0,    8, TYPED,     0, 0, 0);
    // back-match lands one column left of the query: left_x is floored
    directed_tbl[12] = dir_row(REQ_LOAD,     0,   40020,   30000,    0, PREDICTED, 0, 0, 0);
    directed_tbl[13] = dir_row(REQ_QUERY,    1,       0,       0,    9, PREDICTED, 0, 0, 0);
    directed_tbl[14] = dir_row(REQ_QUERY,    0,       0,       0,   10, PREDICTED, 0, 0, 0);
    // back-match two columns away fails the cross-check
    directed_tbl[15] = dir_row(REQ_LOAD,     2,   40030,   40000,    0, PREDICTED, 0, 0, 0);
    directed_tbl[16] = dir_row(REQ_QUERY,    2,       0,       0,   11, TYPED,     0, 0, 0);
    // difference exactly at the threshold still matches
    directed_tbl[17] = dir_row(REQ_LOAD,     3,   60000,   60041,    0, PREDICTED, 0, 0, 0);
    directed_tbl[18] = dir_row(REQ_QUERY,    3,       0,       0,   12, TYPED,     1, 3, 3);
    // one past the threshold: right scan runs off the row end
    directed_tbl[19] = dir_row(REQ_LOAD,     3,   60000,   60042,    0, PREDICTED, 0, 0, 0);
    directed_tbl[20] = dir_row(REQ_QUERY,    3,       0,       0,   13, TYPED,     0, 0, 0);
    // one LSB above min_phase passes
    directed_tbl[21] = dir_row(REQ_LOAD,     1,   25737,   25737,    0, PREDICTED, 0, 0, 0);
    directed_tbl[22] = dir_row(REQ_QUERY,    1,       0,       0,   14, TYPED,     1, 1, 1);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    write_reg(REG_ROW_WIDTH, 4);
    send_idle_pct = 31;
    recv_idle_pct = 88;
    foreach (directed_tbl[i]) send_item(directed_tbl[i]);

    // Receiver sparse then sender sparse, then free-running; the unfilled
    // phase stays inside columns a filled phase has already loaded.
    //        min_phase  threshold  width  items  sidle  ridle  fill hold pause
    run_phase(25736,     41,        8,     30,    31,    88,    1,   0,   0);
    run_phase(0,         0,         1,     15,    31,    88,    1,   0,   0);
    run_phase(1048575,   1048575,   16,    20,    88,    31,    1,   0,   0);
    run_phase(12000,     200,       32,    30,    88,    31,    1,   0,   1);
    run_phase(0,         1048575,   30,    15,    0,     0,     0,   0,   0);
    run_phase(30000,     90,        40,    30,    0,     0,     1,   1,   0);
    run_phase(25736,     41,        12,    25,    0,     0,     1,   0,   0);

    drain_results(DRAIN_CYCLES);
    if (mismatch_count == 0 && pending_matches.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
